// ===== hdl/cdo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdo_pkg
// Shared constants, types and calendar helpers for the date offset block.
// ----------------------------------------------------------------------------
package cdo_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int YEAR_IN_W       = 14;
  localparam int YEAR_OUT_W      = 15;
  localparam int MONTH_W         = 4;
  localparam int DAY_W           = 5;
  localparam int YMOD_W          = 9;
  localparam int MONTHS_PER_YEAR = 12;
  localparam int LEAP_CYCLE      = 400;
  localparam int YEAR_MIN        = 1;
  localparam int YEAR_MAX        = 9999;

  localparam logic [MONTH_W-1:0] MON_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MON_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MON_DEC = MONTH_W'(MONTHS_PER_YEAR);

  typedef struct packed {
    logic done;
    logic year_inc;
    logic year_dec;
  } cdo_step_t;

  // leap test on the year taken mod 400
  function automatic logic cdo_leap(input logic [YMOD_W-1:0] r);
    return (r[1:0] == 2'd0) &&
           (r != YMOD_W'(100)) && (r != YMOD_W'(200)) && (r != YMOD_W'(300));
  endfunction

  function automatic logic [DAY_W-1:0] cdo_month_len(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
    logic [DAY_W-1:0] n;
    case (m)
      MON_FEB:                   n = leap ? DAY_W'(29) : DAY_W'(28);
      4'd4, 4'd6, 4'd9, 4'd11:   n = DAY_W'(30);
      default:                   n = DAY_W'(31);
    endcase
    return n;
  endfunction

endpackage

// ===== hdl/cdo_step_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdo_step_unit
// One month of the walk: a shared compare-subtract on the remaining count
// decides between absorbing it in the month and crossing into the next one
// (forward) or the previous one (backward).
module cdo_step_unit #(
  parameter int OFFSET_BITS = cdo_pkg::OFFSET_BITS_DEF
) (
  input  logic                         direction,
  input  logic [OFFSET_BITS-1:0]       left,
  input  logic [cdo_pkg::MONTH_W-1:0]  month,
  input  logic [cdo_pkg::DAY_W-1:0]    day,
  input  logic [cdo_pkg::YMOD_W-1:0]   ymod,
  output logic [OFFSET_BITS-1:0]       left_next,
  output logic [cdo_pkg::MONTH_W-1:0]  month_next,
  output logic [cdo_pkg::DAY_W-1:0]    day_next,
  output logic [cdo_pkg::YMOD_W-1:0]   ymod_next,
  output cdo_pkg::cdo_step_t           status
);

  logic [cdo_pkg::DAY_W-1:0]   md;
  logic [cdo_pkg::DAY_W:0]     sub;
  logic [OFFSET_BITS:0]        diff;
  logic [cdo_pkg::YMOD_W-1:0]  ymod_prev;
  logic [cdo_pkg::MONTH_W-1:0] month_prev;

  assign md   = cdo_pkg::cdo_month_len(month, cdo_pkg::cdo_leap(ymod));
  assign sub  = direction ? {1'b0, day}
                          : ({1'b0, md} - {1'b0, day} + (cdo_pkg::DAY_W+1)'(1));
  assign diff = {1'b0, left} - (OFFSET_BITS+1)'(sub);

  assign ymod_prev  = (ymod == '0) ? cdo_pkg::YMOD_W'(cdo_pkg::LEAP_CYCLE - 1)
                                   : ymod - cdo_pkg::YMOD_W'(1);
  assign month_prev = (month == cdo_pkg::MON_JAN) ? cdo_pkg::MON_DEC
                                                  : month - cdo_pkg::MONTH_W'(1);

  always_comb begin
    left_next       = left;
    month_next      = month;
    day_next        = day;
    ymod_next       = ymod;
    status.done     = 1'b0;
    status.year_inc = 1'b0;
    status.year_dec = 1'b0;
    if (left == '0) begin
      status.done = 1'b1;
    end else if (diff[OFFSET_BITS]) begin
      // count ends inside this month
      status.done = 1'b1;
      left_next   = '0;
      day_next    = direction ? day - left[cdo_pkg::DAY_W-1:0]
                              : day + left[cdo_pkg::DAY_W-1:0];
    end else begin
      left_next = diff[OFFSET_BITS-1:0];
      if (!direction) begin
        day_next = cdo_pkg::DAY_W'(1);
        if (month == cdo_pkg::MON_DEC) begin
          month_next      = cdo_pkg::MON_JAN;
          status.year_inc = 1'b1;
          ymod_next       = (ymod == cdo_pkg::YMOD_W'(cdo_pkg::LEAP_CYCLE - 1))
                            ? '0 : ymod + cdo_pkg::YMOD_W'(1);
        end else begin
          month_next = month + cdo_pkg::MONTH_W'(1);
        end
      end else begin
        month_next = month_prev;
        if (month == cdo_pkg::MON_JAN) begin
          status.year_dec = 1'b1;
          ymod_next       = ymod_prev;
          day_next        = cdo_pkg::cdo_month_len(month_prev, cdo_pkg::cdo_leap(ymod_prev));
        end else begin
          day_next = cdo_pkg::cdo_month_len(month_prev, cdo_pkg::cdo_leap(ymod));
        end
      end
    end
  end

endmodule

// ===== hdl/calendar_date_day_offset.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_day_offset
// Moves a Gregorian date forward or backward by a count of days.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat (in_valid/in_stall): direction, start date, day_offset.
//   Output beat (out_valid/out_stall): result date and an out-of-range flag
//   for years outside 1..9999.
//   in_stall is high while an item is in work; one item is handled at a time.
//   After acceptance the year is reduced mod 400 by repeated subtraction, the
//   start day is clamped to the month length, then the walk crosses one month
//   per step through the shared step unit until the count is used up; a
//   closing step writes the result register.
//   The next input beat is taken only once the walk has ended.
//   The result sits in an output register; a new input beat is taken while
//   it waits. If the receiver stalls and the register is still full when the
//   next walk ends, that walk holds until the register drains.
//   rst clears the sequencer and the output valid; no result is pending.
// ----------------------------------------------------------------------------
module calendar_date_day_offset #(
  parameter int OFFSET_BITS = cdo_pkg::OFFSET_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              direction,
  input  logic [cdo_pkg::YEAR_IN_W-1:0]     start_year,
  input  logic [cdo_pkg::MONTH_W-1:0]       start_month,
  input  logic [cdo_pkg::DAY_W-1:0]         start_day,
  input  logic [OFFSET_BITS-1:0]            day_offset,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [cdo_pkg::YEAR_OUT_W-1:0] result_year,
  output logic [cdo_pkg::MONTH_W-1:0]       result_month,
  output logic [cdo_pkg::DAY_W-1:0]         result_day,
  output logic                              year_out_of_range
);

  localparam int YEAR_W = ((OFFSET_BITS - 8 > cdo_pkg::YEAR_IN_W) ?
                           (OFFSET_BITS - 8) : cdo_pkg::YEAR_IN_W) + 2;
  localparam int MOD_STEPS = 6;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOD  = 2'd1;
  localparam logic [1:0] S_NORM = 2'd2;
  localparam logic [1:0] S_WALK = 2'd3;

  logic [1:0]                        state;
  logic [2:0]                        step;
  logic                              dir;
  logic signed [YEAR_W-1:0]          year;
  logic [cdo_pkg::YEAR_IN_W-1:0]     ymod;
  logic [cdo_pkg::MONTH_W-1:0]       month;
  logic [cdo_pkg::DAY_W-1:0]         day;
  logic [OFFSET_BITS-1:0]            left;

  logic [OFFSET_BITS-1:0]            left_next;
  logic [cdo_pkg::MONTH_W-1:0]       month_next;
  logic [cdo_pkg::DAY_W-1:0]         day_next;
  logic [cdo_pkg::YMOD_W-1:0]        ymod_next;
  cdo_pkg::cdo_step_t                status;

  logic                              in_take;
  logic                              out_free;
  logic [cdo_pkg::MONTH_W-1:0]       month_in;
  logic [cdo_pkg::YEAR_IN_W:0]       mod_diff;
  logic [cdo_pkg::DAY_W-1:0]         md_start;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign month_in = (start_month == '0) ? cdo_pkg::MON_JAN :
                    (start_month > cdo_pkg::MON_DEC) ? cdo_pkg::MON_DEC : start_month;

  // binary long division remainder, largest multiple of 400 first
  assign mod_diff = {1'b0, ymod} -
                    ((cdo_pkg::YEAR_IN_W+1)'(cdo_pkg::LEAP_CYCLE) << step);

  assign md_start = cdo_pkg::cdo_month_len(month,
                      cdo_pkg::cdo_leap(ymod[cdo_pkg::YMOD_W-1:0]));

  cdo_step_unit #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_step (
    .direction  (dir),
    .left       (left),
    .month      (month),
    .day        (day),
    .ymod       (ymod[cdo_pkg::YMOD_W-1:0]),
    .left_next  (left_next),
    .month_next (month_next),
    .day_next   (day_next),
    .ymod_next  (ymod_next),
    .status     (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_WALK) && status.done && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            state <= S_MOD;
            step  <= 3'(MOD_STEPS - 1);
          end
        end
        S_MOD: begin
          if (step == '0) begin
            state <= S_NORM;
          end else begin
            step <= step - 3'd1;
          end
        end
        S_NORM: begin
          state <= S_WALK;
        end
        S_WALK: begin
          if (status.done && out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_take) begin
          dir   <= direction;
          year  <= YEAR_W'(start_year);
          ymod  <= start_year;
          month <= month_in;
          day   <= (start_day == '0) ? cdo_pkg::DAY_W'(1) : start_day;
          left  <= day_offset;
        end
      end
      S_MOD: begin
        if (!mod_diff[cdo_pkg::YEAR_IN_W]) begin
          ymod <= mod_diff[cdo_pkg::YEAR_IN_W-1:0];
        end
      end
      S_NORM: begin
        if (day > md_start) begin
          day <= md_start;
        end
      end
      S_WALK: begin
        if (!status.done) begin
          left  <= left_next;
          month <= month_next;
          day   <= day_next;
          ymod  <= cdo_pkg::YEAR_IN_W'(ymod_next);
          if (status.year_inc) begin
            year <= year + YEAR_W'(1);
          end else if (status.year_dec) begin
            year <= year - YEAR_W'(1);
          end
        end else if (out_free) begin
          result_year       <= year[cdo_pkg::YEAR_OUT_W-1:0];
          result_month      <= month_next;
          result_day        <= day_next;
          year_out_of_range <= (year < YEAR_W'(cdo_pkg::YEAR_MIN)) ||
                               (year > YEAR_W'(cdo_pkg::YEAR_MAX));
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== test/tb_calendar_date_day_offset.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_calendar_date_day_offset
// Self-checking bench for the Gregorian date offset block. A directed table
// covers zero offsets, month and day saturation, leap and century rules,
// year range edges and the largest offsets in both directions. A random
// phase follows. Every result beat is compared field by field with the
// table's expected date or with an in-bench date walker. The sender works in
// bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_calendar_date_day_offset;

  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_BWD = 1'b1;
  localparam int   OFF_W          = cdo_pkg::OFFSET_BITS_DEF;
  localparam int   NUM_DIRECTED   = 24;
  localparam int   RANDOM_BEATS   = 246;
  localparam int   CYCLE_LIMIT    = 3_000_000;

  typedef struct packed {
    logic signed [cdo_pkg::YEAR_OUT_W-1:0] year;
    logic [cdo_pkg::MONTH_W-1:0]           month;
    logic [cdo_pkg::DAY_W-1:0]             day;
    logic                                  out_of_range;
  } date_t;

  typedef struct {
    logic dir;
    int   year;
    int   month;
    int   day;
    int   offset;
    bit   known;
    int   exp_year;
    int   exp_month;
    int   exp_day;
    bit   exp_oor;
  } offset_case_t;

  logic                            clk         = 1'b0;
  logic                            rst         = 1'b1;
  logic                            in_valid    = 1'b0;
  logic                            direction   = DIR_FWD;
  logic [cdo_pkg::YEAR_IN_W-1:0]   start_year  = '0;
  logic [cdo_pkg::MONTH_W-1:0]     start_month = '0;
  logic [cdo_pkg::DAY_W-1:0]       start_day   = '0;
  logic [OFF_W-1:0]                day_offset  = '0;
  logic                            out_stall   = 1'b0;
  logic                            in_stall;
  logic                            out_valid;
  logic signed [cdo_pkg::YEAR_OUT_W-1:0] result_year;
  logic [cdo_pkg::MONTH_W-1:0]     result_month;
  logic [cdo_pkg::DAY_W-1:0]       result_day;
  logic                            year_out_of_range;

  date_t expected_dates[$];
  int    mismatch_count = 0;
  int    cycle_count    = 0;
  int    burst_left     = 0;

  offset_case_t directed_cases [NUM_DIRECTED] = '{
    '{DIR_FWD, 2024,  1,  1,     0, 1,  2024,  1,  1, 0},
    '{DIR_BWD, 9999, 12, 31,     0, 1,  9999, 12, 31, 0},
    '{DIR_FWD, 9999, 12, 31,     1, 1, 10000,  1,  1, 1},
    '{DIR_BWD,    1,  1,  1,     1, 1,     0, 12, 31, 1},
    '{DIR_FWD, 2024,  2, 28,     1, 1,  2024,  2, 29, 0},
    '{DIR_FWD, 2023,  2, 28,     1, 1,  2023,  3,  1, 0},
    '{DIR_FWD, 1900,  2, 28,     1, 1,  1900,  3,  1, 0},
    '{DIR_FWD, 2000,  2, 28,     1, 1,  2000,  2, 29, 0},
    '{DIR_BWD, 2024,  3,  1,     1, 1,  2024,  2, 29, 0},
    '{DIR_BWD, 2100,  3,  1,     1, 1,  2100,  2, 28, 0},
    '{DIR_FWD, 2023, 12, 31,     1, 1,  2024,  1,  1, 0},
    '{DIR_BWD, 2024,  1,  1,     1, 1,  2023, 12, 31, 0},
    '{DIR_FWD, 2024,  0, 15,     0, 1,  2024,  1, 15, 0},
    '{DIR_BWD, 2024, 15, 10,     0, 1,  2024, 12, 10, 0},
    '{DIR_FWD, 2024,  3,  0,     0, 1,  2024,  3,  1, 0},
    '{DIR_FWD, 2023,  4, 31,     0, 1,  2023,  4, 30, 0},
    '{DIR_BWD, 2023,  2, 31,     0, 1,  2023,  2, 28, 0},
    '{DIR_FWD,    0,  2, 28,     1, 1,     0,  2, 29, 1},
    '{DIR_FWD, 16383, 12, 31,    1, 0,     0,  0,  0, 0},
    '{DIR_FWD,    1,  1,  1, 65535, 0,     0,  0,  0, 0},
    '{DIR_BWD,    0,  1,  1, 65535, 0,     0,  0,  0, 0},
    '{DIR_BWD, 9999,  1,  1, 65535, 0,     0,  0,  0, 0},
    '{DIR_FWD, 16383, 15, 31, 65535, 0,    0,  0,  0, 0},
    '{DIR_FWD, 2024,  1, 31,    30, 0,     0,  0,  0, 0}
  };

  calendar_date_day_offset #(
    .OFFSET_BITS(OFF_W)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .direction        (direction),
    .start_year       (start_year),
    .start_month      (start_month),
    .start_day        (start_day),
    .day_offset       (day_offset),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .result_year      (result_year),
    .result_month     (result_month),
    .result_day       (result_day),
    .year_out_of_range(year_out_of_range)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int month_days(input int y, input int m);
    bit leap;
    int n;
    leap = (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    case (m)
      2:           n = leap ? 29 : 28;
      4, 6, 9, 11: n = 30;
      default:     n = 31;
    endcase
    return n;
  endfunction

  function automatic date_t offset_date(input logic dir, input int y_in, input int m_in,
                                        input int d_in, input int days);
    int    y;
    int    m;
    int    d;
    int    left;
    int    md;
    date_t r;
    y    = y_in;
    m    = m_in;
    d    = d_in;
    left = days & ((1 << OFF_W) - 1);
    if (m < 1) m = 1;
    if (m > cdo_pkg::MONTHS_PER_YEAR) m = cdo_pkg::MONTHS_PER_YEAR;
    md = month_days(y, m);
    if (d < 1) d = 1;
    if (d > md) d = md;
    if (dir == DIR_FWD) begin
      while (left > 0) begin
        md = month_days(y, m);
        if (d + left <= md) begin
          d    = d + left;
          left = 0;
        end else begin
          left = left - (md - d + 1);
          m    = m + 1;
          if (m > cdo_pkg::MONTHS_PER_YEAR) begin
            m = 1;
            y = y + 1;
          end
          d = 1;
        end
      end
    end else begin
      while (left > 0) begin
        if (d > left) begin
          d    = d - left;
          left = 0;
        end else begin
          left = left - d;
          m    = m - 1;
          if (m == 0) begin
            m = cdo_pkg::MONTHS_PER_YEAR;
            y = y - 1;
          end
          d = month_days(y, m);
        end
      end
    end
    r.year         = y[cdo_pkg::YEAR_OUT_W-1:0];
    r.month        = m[cdo_pkg::MONTH_W-1:0];
    r.day          = d[cdo_pkg::DAY_W-1:0];
    r.out_of_range = (y < cdo_pkg::YEAR_MIN) || (y > cdo_pkg::YEAR_MAX);
    return r;
  endfunction

  // one input beat, then the sender's idle pattern or a full drain
  task automatic send_date(input logic dir, input int y, input int m, input int d,
                           input int days, input bit known, input date_t known_res,
                           input bit drain_after);
    int gap;
    in_valid    <= 1'b1;
    direction   <= dir;
    start_year  <= y[cdo_pkg::YEAR_IN_W-1:0];
    start_month <= m[cdo_pkg::MONTH_W-1:0];
    start_day   <= d[cdo_pkg::DAY_W-1:0];
    day_offset  <= days[OFF_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_dates.push_back(known ? known_res : offset_date(dir, y, m, d, days));
    if (drain_after) begin
      in_valid <= 1'b0;
      while (expected_dates.size() != 0) @(posedge clk);
    end else begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 8);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // receiver stall pattern
  initial begin : out_stall_pattern
    int hold;
    int free_run;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 4) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(50, 300)) @(posedge clk);
      end else begin
        hold     = $urandom_range(1, 12);
        free_run = $urandom_range(1, 10);
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
        repeat (free_run) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    date_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_dates.size() == 0) begin
        $error("unexpected result beat: %0d-%0d-%0d", result_year, result_month, result_day);
        mismatch_count++;
      end else begin
        want = expected_dates.pop_front();
        if (result_year !== want.year) begin
          $error("result_year: expected %0d, got %0d", want.year, result_year);
          mismatch_count++;
        end
        if (result_month !== want.month) begin
          $error("result_month: expected %0d, got %0d", want.month, result_month);
          mismatch_count++;
        end
        if (result_day !== want.day) begin
          $error("result_day: expected %0d, got %0d", want.day, result_day);
          mismatch_count++;
        end
        if (year_out_of_range !== want.out_of_range) begin
          $error("year_out_of_range: expected %0d, got %0d", want.out_of_range,
                 year_out_of_range);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    offset_case_t c;
    date_t        typed;
    logic         dir;
    int           y;
    int           m;
    int           d;
    int           days;
    int           sel;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      c                  = directed_cases[i];
      typed.year         = c.exp_year[cdo_pkg::YEAR_OUT_W-1:0];
      typed.month        = c.exp_month[cdo_pkg::MONTH_W-1:0];
      typed.day          = c.exp_day[cdo_pkg::DAY_W-1:0];
      typed.out_of_range = c.exp_oor;
      send_date(c.dir, c.year, c.month, c.day, c.offset, c.known, typed,
                i == NUM_DIRECTED - 1);
    end

    typed = '0;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      dir = $urandom_range(0, 1) ? DIR_BWD : DIR_FWD;

      sel = $urandom_range(0, 99);
      if (sel < 50)      y = $urandom_range(1, 9999);
      else if (sel < 65) y = $urandom_range(1895, 2405);
      else if (sel < 75) y = $urandom_range(0, 3);
      else if (sel < 85) y = $urandom_range(9995, 9999);
      else               y = $urandom_range(0, 16383);

      sel = $urandom_range(0, 99);
      if (sel < 88) m = $urandom_range(1, 12);
      else          m = $urandom_range(0, 15);

      sel = $urandom_range(0, 99);
      if (sel < 8)       d = 0;
      else if (sel < 80) d = $urandom_range(1, 31);
      else               d = $urandom_range(27, 31);

      // mostly short walks, a few across the whole offset range
      sel = $urandom_range(0, 99);
      if (sel < 5)       days = 0;
      else if (sel < 75) days = $urandom_range(1, 400);
      else if (sel < 92) days = $urandom_range(1, 3000);
      else               days = $urandom_range(0, 65535);

      send_date(dir, y, m, d, days, 1'b0, typed, i == RANDOM_BEATS / 2);
    end

    in_valid <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_dates.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/cdo_pkg.sv
hdl/cdo_step_unit.sv
hdl/calendar_date_day_offset.sv
test/tb_calendar_date_day_offset.sv
